// ----- design/plp_pkg.sv -----
`timescale 1ns / 1ps
// Port list parser package: widths, character codes, phase, error and
// controller state codes, and the command and status bundles.
// No dependencies.
package plp_pkg;

  localparam int unsigned MAX_PORT_DEF   = 65535;
  localparam int unsigned WORD_BITS_DEF  = 32;
  localparam int unsigned MAX_DIGITS_DEF = 5;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned WIDX_W   = 11;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned OUT_W    = 32;
  localparam int unsigned ACC_W    = 17;
  localparam int unsigned DCNT_W   = 3;
  localparam int unsigned DIGIT_W  = 4;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;

  typedef enum logic [1:0] {
    PH_START,
    PH_NUMBER,
    PH_SPAN,
    PH_SECOND
  } phase_e;

  typedef enum logic [STATUS_W-1:0] {
    ERR_NONE,
    ERR_START_CHAR,
    ERR_PORT_RANGE,
    ERR_NUM_CHAR,
    ERR_NO_SECOND,
    ERR_BAD_RANGE,
    ERR_SECOND_CHAR,
    ERR_DIGITS
  } err_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CLEAR,
    ST_PARSE,
    ST_DIV,
    ST_FILL_RD,
    ST_FILL_WR,
    ST_READ,
    ST_READ_WAIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic clr_init;
    logic clr_wr;
    logic parse;
    logic div_step;
    logic fill_wr;
    logic rd_sel;
    logic rd_capture;
    logic push;
  } plp_cmd_t;

  typedef struct packed {
    logic action;
    logic new_string;
    logic need_fill;
    logic last_word;
    logic clr_done;
  } plp_stat_t;

endpackage

// ----- design/plp_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the port list parser: input items and
// result items. Depends on plp_pkg.
interface plp_in_if;
  import plp_pkg::*;
  logic              valid;
  logic              ready;
  logic              action;
  logic [CHAR_W-1:0] character;
  logic              last;
  logic [WIDX_W-1:0] word_index;

  modport source (output valid, action, character, last, word_index, input ready);
  modport sink   (input valid, action, character, last, word_index, output ready);
endinterface

interface plp_out_if;
  import plp_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                finished;
  logic [OUT_W-1:0]    bitmap_word;

  modport source (output valid, status, finished, bitmap_word, input ready);
  modport sink   (input valid, status, finished, bitmap_word, output ready);
endinterface

// ----- design/port_list_parser.sv -----
`timescale 1ns / 1ps
// Port list parser top level: controller plus datapath behind two
// valid/ready channels. Uses plp_pkg, plp_if, plp_ctrl, plp_dp.
//
// Input channel in_i carries one item per transfer: action 0 parses one
// character of a comma-separated list of ports and dash ranges, action 1
// reads one bitmap word. Output channel out_o returns exactly one result
// per item: status (first error code, 0 if none), finished, bitmap_word.
// Steps after the input transfer, up to the result being offered:
//   read: decode, RAM read, capture; parse: decode, character step.
//   first character of a string: plus a clearing sweep of all NUM_WORDS
//     words of the bitmap RAM (2048 by default), one word per cycle.
//   committed port or range: plus a divider step to split the range ends
//     into word index and bit, then a read and a write per bitmap word touched
//     (read-modify-write on the single RAM port pair).
// One item is in work at a time; a new item is taken in the cycle after the
// previous result is handed to the output register, so a stalled receiver
// holds only one result and the next item can still be processed.
// Reset empties the output register and marks the bitmap as unwritten:
// reads return zero until the first string has started.
module port_list_parser #(
  parameter int unsigned MAX_PORT   = plp_pkg::MAX_PORT_DEF,
  parameter int unsigned WORD_BITS  = plp_pkg::WORD_BITS_DEF,
  parameter int unsigned MAX_DIGITS = plp_pkg::MAX_DIGITS_DEF
) (
  input logic         clk_i,
  input logic         rst_ni,
  plp_in_if.sink      in_i,
  plp_out_if.source   out_o
);
  import plp_pkg::*;

  plp_cmd_t  cmd;
  plp_stat_t stat;

  plp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  plp_dp #(
    .MAX_PORT   (MAX_PORT),
    .WORD_BITS  (WORD_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .action_i      (in_i.action),
    .character_i   (in_i.character),
    .last_i        (in_i.last),
    .word_index_i  (in_i.word_index),
    .status_o      (out_o.status),
    .finished_o    (out_o.finished),
    .bitmap_word_o (out_o.bitmap_word)
  );

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("input taken while an item is in work");

  a_push_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |-> (!out_o.valid || out_o.ready))
    else $error("result overwrites a pending result");

  a_string_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(stat.new_string) |-> $past(cmd.clr_wr))
    else $error("string started without a bitmap clear");

endmodule

// ----- design/plp_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module plp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/plp_ctrl.sv -----
`timescale 1ns / 1ps
// Port list parser controller: sequences decode, bitmap clear, parse,
// port division, word fill and reads; owns the channel handshakes. Uses plp_pkg.
module plp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  input  plp_pkg::plp_stat_t  stat_i,
  output plp_pkg::plp_cmd_t   cmd_o
);
  import plp_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (stat_i.action) begin
          state_d = ST_READ;
        end else if (stat_i.new_string) begin
          cmd_o.clr_init = 1'b1;
          state_d        = ST_CLEAR;
        end else begin
          state_d = ST_PARSE;
        end
      end
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_done) begin
          state_d = ST_PARSE;
        end
      end
      ST_PARSE: begin
        cmd_o.parse = 1'b1;
        state_d     = stat_i.need_fill ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        state_d        = ST_FILL_RD;
      end
      ST_FILL_RD: begin
        state_d = ST_FILL_WR;
      end
      ST_FILL_WR: begin
        cmd_o.fill_wr = 1'b1;
        state_d       = stat_i.last_word ? ST_DONE : ST_FILL_RD;
      end
      ST_READ: begin
        cmd_o.rd_sel = 1'b1;
        state_d      = ST_READ_WAIT;
      end
      ST_READ_WAIT: begin
        cmd_o.rd_capture = 1'b1;
        state_d          = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.push  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- design/plp_dp.sv -----
`timescale 1ns / 1ps
// Port list parser datapath: item and parser registers, character step,
// constant divider for port to word/bit, bitmap RAM and result register.
// Uses plp_pkg and plp_ram.
module plp_dp #(
  parameter int unsigned MAX_PORT   = plp_pkg::MAX_PORT_DEF,
  parameter int unsigned WORD_BITS  = plp_pkg::WORD_BITS_DEF,
  parameter int unsigned MAX_DIGITS = plp_pkg::MAX_DIGITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  plp_pkg::plp_cmd_t             cmd_i,
  output plp_pkg::plp_stat_t            stat_o,
  input  logic                          action_i,
  input  logic [plp_pkg::CHAR_W-1:0]    character_i,
  input  logic                          last_i,
  input  logic [plp_pkg::WIDX_W-1:0]    word_index_i,
  output logic [plp_pkg::STATUS_W-1:0]  status_o,
  output logic                          finished_o,
  output logic [plp_pkg::OUT_W-1:0]     bitmap_word_o
);
  import plp_pkg::*;

  localparam int unsigned NUM_WORDS = MAX_PORT / WORD_BITS + 1;
  localparam int unsigned ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned PORT_W    = $clog2(MAX_PORT + 1);
  localparam int unsigned BIT_W     = $clog2(WORD_BITS);
  // reciprocal of the word width, exact for every port below 2**PORT_W
  localparam int unsigned RSH       = PORT_W + BIT_W;
  localparam int unsigned PROD_W    = 2 * PORT_W + 1;
  localparam logic [PORT_W:0] RCP   =
    (PORT_W + 1)'(((64'd1 << RSH) + 64'(WORD_BITS) - 64'd1) / 64'(WORD_BITS));

  // item registers
  logic              item_action_q;
  logic [CHAR_W-1:0] item_char_q;
  logic              item_last_q;
  logic [WIDX_W-1:0] item_widx_q;

  // parser state
  phase_e             ph_q;
  logic [ACC_W-1:0]   acc_q;
  logic [DCNT_W-1:0]  dc_q;
  logic [PORT_W-1:0]  rlo_q;
  err_e               err_q;
  logic               ns_q;
  logic               bm_valid_q;
  logic [ADDR_W-1:0]  w_q;

  // range ends: 0 range low, 1 range high
  logic [PORT_W-1:0] end_port_q [2];
  logic [PROD_W-1:0] prod       [2];
  logic [ADDR_W-1:0] word_n     [2];
  logic [BIT_W-1:0]  bit_n      [2];
  logic [ADDR_W-1:0] word_q     [2];
  logic [BIT_W-1:0]  bit_q      [2];

  logic [OUT_W-1:0]    res_word_q;
  logic [STATUS_W-1:0] out_status_q;
  logic                out_fin_q;
  logic [OUT_W-1:0]    out_word_q;

  // character step
  phase_e            ph_n;
  logic [ACC_W-1:0]  acc_n;
  logic [DCNT_W-1:0] dc_n;
  logic [PORT_W-1:0] rlo_n;
  err_e              err_n;
  logic              fill_n;
  logic [PORT_W-1:0] fill_lo, fill_hi;
  logic              is_dig, comma_commit;
  logic [DIGIT_W-1:0] dig;

  always_comb begin
    ph_n         = ph_q;
    acc_n        = acc_q;
    dc_n         = dc_q;
    rlo_n        = rlo_q;
    err_n        = err_q;
    fill_n       = 1'b0;
    fill_lo      = '0;
    fill_hi      = '0;
    comma_commit = 1'b0;
    is_dig       = (item_char_q >= CH_ZERO) && (item_char_q <= CH_NINE);
    dig          = DIGIT_W'(item_char_q - CH_ZERO);
    if (err_q == ERR_NONE) begin
      case (ph_q)
        PH_START: begin
          if (is_dig) begin
            acc_n = ACC_W'(dig);
            dc_n  = DCNT_W'(1);
            ph_n  = PH_NUMBER;
          end else if (item_char_q != CH_COMMA) begin
            err_n = ERR_START_CHAR;
          end
        end
        PH_NUMBER, PH_SECOND: begin
          if (is_dig) begin
            if (dc_q >= DCNT_W'(MAX_DIGITS)) begin
              err_n = ERR_DIGITS;
            end else begin
              acc_n = ACC_W'((acc_q << 3) + (acc_q << 1) + ACC_W'(dig));
              dc_n  = dc_q + DCNT_W'(1);
            end
          end else if (item_char_q == CH_COMMA) begin
            comma_commit = 1'b1;
          end else if (item_char_q == CH_DASH && ph_q == PH_NUMBER) begin
            rlo_n = (acc_q > ACC_W'(MAX_PORT)) ? '0 : PORT_W'(acc_q);
            ph_n  = PH_SPAN;
          end else begin
            err_n = (ph_q == PH_NUMBER) ? ERR_NUM_CHAR : ERR_SECOND_CHAR;
          end
        end
        PH_SPAN: begin
          if (is_dig) begin
            acc_n = ACC_W'(dig);
            dc_n  = DCNT_W'(1);
            ph_n  = PH_SECOND;
          end else begin
            err_n = ERR_NO_SECOND;
          end
        end
        default: begin
          ph_n = PH_START;
        end
      endcase
      // separator or end of string commits what is pending
      if (err_n == ERR_NONE && (comma_commit || item_last_q)) begin
        case (ph_n)
          PH_NUMBER: begin
            if (acc_n == '0 || acc_n > ACC_W'(MAX_PORT)) begin
              err_n = ERR_PORT_RANGE;
            end else begin
              fill_n  = 1'b1;
              fill_lo = PORT_W'(acc_n);
              fill_hi = PORT_W'(acc_n);
              ph_n    = PH_START;
            end
          end
          PH_SPAN: begin
            err_n = ERR_NO_SECOND;
          end
          PH_SECOND: begin
            if (rlo_n == '0 || acc_n > ACC_W'(MAX_PORT) || ACC_W'(rlo_n) > acc_n) begin
              err_n = ERR_BAD_RANGE;
            end else begin
              fill_n  = 1'b1;
              fill_lo = rlo_n;
              fill_hi = PORT_W'(acc_n);
              ph_n    = PH_START;
            end
          end
          default: begin
            ph_n = PH_START;
          end
        endcase
      end
    end
  end

  // word index and bit of each range end
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      prod[i]   = PROD_W'(end_port_q[i]) * PROD_W'(RCP);
      word_n[i] = ADDR_W'(prod[i] >> RSH);
      bit_n[i]  = BIT_W'(end_port_q[i] - PORT_W'(word_n[i]) * PORT_W'(WORD_BITS));
    end
  end

  // bitmap RAM
  logic [WORD_BITS-1:0] ones, mask, lo_mask, hi_mask;
  logic [WORD_BITS-1:0] ram_rdata, ram_wdata;
  logic [ADDR_W-1:0]    ram_raddr, w_lo, w_hi;
  logic                 ram_we;
  logic [OUT_W-1:0]     rdata_out;

  assign ones      = '1;
  assign w_lo      = word_q[0];
  assign w_hi      = word_q[1];
  assign lo_mask   = (w_q == w_lo) ? (ones << bit_q[0]) : ones;
  assign hi_mask   = (w_q == w_hi) ? (ones >> (BIT_W'(WORD_BITS - 1) - bit_q[1])) : ones;
  assign mask      = lo_mask & hi_mask;
  assign ram_we    = cmd_i.fill_wr || cmd_i.clr_wr;
  assign ram_wdata = cmd_i.clr_wr ? '0 : (ram_rdata | mask);
  assign ram_raddr = cmd_i.rd_sel ? ADDR_W'(item_widx_q) : w_q;

  plp_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NUM_WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (w_q),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  if (WORD_BITS >= OUT_W) begin : g_word_trunc
    assign rdata_out = ram_rdata[OUT_W-1:0];
  end else begin : g_word_ext
    assign rdata_out = {{(OUT_W - WORD_BITS){1'b0}}, ram_rdata};
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q       <= PH_START;
      acc_q      <= '0;
      dc_q       <= '0;
      rlo_q      <= '0;
      err_q      <= ERR_NONE;
      ns_q       <= 1'b1;
      bm_valid_q <= 1'b0;
      w_q        <= '0;
    end else begin
      if (cmd_i.clr_init) begin
        w_q <= '0;
      end
      if (cmd_i.clr_wr) begin
        w_q <= w_q + ADDR_W'(1);
        if (stat_o.clr_done) begin
          ph_q       <= PH_START;
          acc_q      <= '0;
          dc_q       <= '0;
          rlo_q      <= '0;
          err_q      <= ERR_NONE;
          ns_q       <= 1'b0;
          bm_valid_q <= 1'b1;
        end
      end
      if (cmd_i.parse) begin
        ph_q  <= ph_n;
        acc_q <= acc_n;
        dc_q  <= dc_n;
        rlo_q <= rlo_n;
        err_q <= err_n;
        if (item_last_q) begin
          ns_q <= 1'b1;
        end
      end
      if (cmd_i.div_step) begin
        w_q <= word_n[0];
      end
      if (cmd_i.fill_wr) begin
        w_q <= w_q + ADDR_W'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_action_q <= action_i;
      item_char_q   <= character_i;
      item_last_q   <= last_i;
      item_widx_q   <= word_index_i;
      res_word_q    <= '0;
    end
    if (cmd_i.parse) begin
      end_port_q[0] <= fill_lo;
      end_port_q[1] <= fill_hi;
    end
    if (cmd_i.div_step) begin
      word_q[0] <= word_n[0];
      word_q[1] <= word_n[1];
      bit_q[0]  <= bit_n[0];
      bit_q[1]  <= bit_n[1];
    end
    if (cmd_i.rd_capture) begin
      res_word_q <= (bm_valid_q && (32'(item_widx_q) < 32'(NUM_WORDS))) ? rdata_out : '0;
    end
    if (cmd_i.push) begin
      out_status_q <= err_q;
      out_fin_q    <= item_action_q ? ns_q : item_last_q;
      out_word_q   <= res_word_q;
    end
  end

  always_comb begin
    stat_o.action     = item_action_q;
    stat_o.new_string = ns_q;
    stat_o.need_fill  = fill_n;
    stat_o.last_word  = (w_q == w_hi);
    stat_o.clr_done   = (w_q == ADDR_W'(NUM_WORDS - 1));
  end

  assign status_o      = out_status_q;
  assign finished_o    = out_fin_q;
  assign bitmap_word_o = out_word_q;

endmodule
